### hw/rtl/rstbl_pkg.sv
`timescale 1ns / 1ps

package rstbl_pkg;

    localparam int CALL_W      = 48;
    localparam int SSID_W      = 4;
    localparam int TIME_W      = 32;
    localparam int ENTRIES_DEF = 20;

    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(6000000);
    localparam logic [TIME_W-1:0] TIME_MAX     = '1;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((CALL_W + SSID_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CALL_W + SSID_W + 7) / 8) * 8;

    typedef enum logic
    {
        OP_HEARD = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [CALL_W-1:0] call;
        logic [SSID_W-1:0] ssid;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### hw/rtl/rstbl_ram.sv
`timescale 1ns / 1ps

module rstbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/recent_station_table_top.sv
`timescale 1ns / 1ps
// The scan sequencer reads (S_READ) and then checks (S_CHECK) each entry in turn through one RAM read port.
// Heard item: the scan stops at a matching entry, else covers all ENTRIES and picks the oldest stamp; then S_WRITE.
// Query item: scans all ENTRIES and can stall on the output; results stream out during the scan.
// Throughput: one item per scan; s_axis_tready is high only between scans.
// Reset (rst_n low, async): table empty, window_ticks = 6000000, no result pending.

module recent_station_table_top
    import rstbl_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration: window_ticks
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIME_W-1:0]    cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // station_call[47:0], station_ssid[51:48], now[83:52]
    input  logic                 s_axis_tuser,  // opcode
    // results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // listed_call[47:0], listed_ssid[51:48]
    output logic                 m_axis_tuser,  // valid_res
    output logic                 m_axis_tlast   // last
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CHECK = 5'b00100,
        S_FINAL = 5'b01000,
        S_WRITE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  window_reg, window_next;
    logic [ENTRIES-1:0] valid_bits_reg, valid_bits_next;

    // latched item
    op_t               op_reg, op_next;
    logic [CALL_W-1:0] call_reg, call_next;
    logic [SSID_W-1:0] ssid_reg, ssid_next;
    logic [TIME_W-1:0] now_reg, now_next;

    // scan state
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [TIME_W-1:0] best_time_reg, best_time_next;
    logic              have_reg, have_next;
    logic [CALL_W-1:0] held_call_reg, held_call_next;
    logic [SSID_W-1:0] held_ssid_reg, held_ssid_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_flag_reg, out_flag_next;
    logic              out_last_reg, out_last_next;
    logic [CALL_W-1:0] out_call_reg, out_call_next;
    logic [SSID_W-1:0] out_ssid_reg, out_ssid_next;

    logic              ram_we;
    entry_t            ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            ent;
    logic              out_free;
    logic              is_match;
    logic              is_older;
    logic              in_window;
    logic [TIME_W-1:0] win_edge;

    rstbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (best_idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // never-written entries read as the cleared value
    assign ent = valid_bits_reg[idx_reg] ? entry_t'(ram_rdata) : '0;

    assign ram_wdata = '{call: call_reg, ssid: ssid_reg, stamp: now_reg};
    assign win_edge  = ent.stamp + window_reg;
    assign is_match  = (ent.call == call_reg) && (ent.ssid == ssid_reg);
    assign is_older  = ent.stamp < best_time_reg;
    assign in_window = (ent.stamp != '0) && (ent.stamp <= now_reg) && (win_edge >= now_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_ssid_reg, out_call_reg});

    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        valid_bits_next = valid_bits_reg;
        op_next         = op_reg;
        call_next       = call_reg;
        ssid_next       = ssid_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_time_next  = best_time_reg;
        have_next       = have_reg;
        held_call_next  = held_call_reg;
        held_ssid_next  = held_ssid_reg;
        out_flag_next   = out_flag_reg;
        out_last_next   = out_last_reg;
        out_call_next   = out_call_reg;
        out_ssid_next   = out_ssid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_we          = 1'b0;

        if (cfg_valid)
        begin
            window_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next        = op_t'(s_axis_tuser);
                    call_next      = s_axis_tdata[CALL_W-1:0];
                    ssid_next      = s_axis_tdata[CALL_W+SSID_W-1:CALL_W];
                    now_next       = s_axis_tdata[CALL_W+SSID_W+TIME_W-1:CALL_W+SSID_W];
                    idx_next       = '0;
                    best_idx_next  = '0;
                    best_time_next = TIME_MAX;
                    have_next      = 1'b0;
                    state_next     = S_READ;
                end
            end

            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (op_reg == OP_HEARD)
                begin
                    if (is_match)
                    begin
                        best_idx_next = idx_reg;
                        state_next    = S_WRITE;
                    end
                    else
                    begin
                        if (is_older)
                        begin
                            best_idx_next  = idx_reg;
                            best_time_next = ent.stamp;
                        end
                        if (idx_reg == IDX_LAST)
                        begin
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                end
                else if (!(in_window && have_reg && !out_free))
                begin
                    // a hit is held back one step so the final one can carry last
                    if (in_window)
                    begin
                        if (have_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_flag_next  = 1'b1;
                            out_last_next  = 1'b0;
                            out_call_next  = held_call_reg;
                            out_ssid_next  = held_ssid_reg;
                        end
                        have_next      = 1'b1;
                        held_call_next = ent.call;
                        held_ssid_next = ent.ssid;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = have_reg;
                    out_last_next  = 1'b1;
                    out_call_next  = have_reg ? held_call_reg : '0;
                    out_ssid_next  = have_reg ? held_ssid_reg : '0;
                    state_next     = S_IDLE;
                end
            end

            S_WRITE:
            begin
                ram_we                        = 1'b1;
                valid_bits_next[best_idx_reg] = 1'b1;
                state_next                    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_reg     <= WINDOW_RESET;
            valid_bits_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_reg     <= window_next;
            valid_bits_reg <= valid_bits_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        call_reg      <= call_next;
        ssid_reg      <= ssid_next;
        now_reg       <= now_next;
        idx_reg       <= idx_next;
        best_idx_reg  <= best_idx_next;
        best_time_reg <= best_time_next;
        have_reg      <= have_next;
        held_call_reg <= held_call_next;
        held_ssid_reg <= held_ssid_next;
        out_flag_reg  <= out_flag_next;
        out_last_reg  <= out_last_next;
        out_call_reg  <= out_call_next;
        out_ssid_reg  <= out_ssid_next;
    end

    a_write_marks_valid : assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_bits_reg[$past(best_idx_reg)])
        else $error("written entry not marked valid");

    a_valid_bits_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |=> (valid_bits_reg & $past(valid_bits_reg)) == $past(valid_bits_reg))
        else $error("valid bit cleared outside reset");

    a_scan_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> idx_reg <= IDX_LAST)
        else $error("scan index beyond table");

    a_empty_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty answer without last");

endmodule
